>>> rtl/core/pictrl_pkg.sv
// shared widths, number format, register map and payload types of the pi controller
package pictrl_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_REGS   = 8;
    localparam int ADDR_WIDTH = $clog2(NUM_REGS * 4);

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // register index, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_TS    = 3'd2,
        REG_SCALE = 3'd3,
        REG_AW_EN = 3'd4,
        REG_THR   = 3'd5,
        REG_UPPER = 3'd6,
        REG_LOWER = 3'd7
    } reg_addr_t;

    typedef struct packed {
        data_t measured_value;
        data_t target_value;
    } in_item_t;

    typedef struct packed {
        data_t drive_value;
        logic  integrating_flag;
    } out_item_t;

endpackage

>>> rtl/core/pi_controller_trapezoid_antiwindup_top.sv
// pi controller with trapezoidal integrator, latched-integrator anti-windup and output clamp
// One sample (measured value, set point) in, one clamped drive value out, all signed Q16.16.
// The block works on one sample at a time: the four chained multiplies (error scale, ki,
// sample period, kp) all run on one bit-serial multiplier at one multiplier bit per cycle,
// and around them run the adds, the anti-windup decision and the clamp. The sample input
// stalls from acceptance until the result is loaded into the output register; a result
// waiting there does not block the next sample.
// Configuration goes through the apb-style port at byte addresses 4*i: kp, ki, sample
// period, error scale, anti-windup enable, windup threshold, upper and lower output limit.
// Write configuration only while no sample is in flight.
module pi_controller_trapezoid_antiwindup_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample channel
    input  logic                                 meas_valid,
    output logic                                 meas_stall,
    input  pictrl_pkg::in_item_t                 meas,
    // result channel
    output logic                                 ctrl_valid,
    input  logic                                 ctrl_stall,
    output pictrl_pkg::out_item_t                ctrl,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pictrl_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import pictrl_pkg::*;

    localparam int TS_W = DATA_WIDTH - 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ERR,
        ST_SUM_E,
        ST_KI,
        ST_TS,
        ST_KP,
        ST_DRV,
        ST_AW,
        ST_OUT
    } state_t;

    function automatic data_t sat_add(input data_t x, input data_t y);
        logic signed [DATA_WIDTH:0] s;
        s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic data_t sat_sub(input data_t x, input data_t y);
        logic signed [DATA_WIDTH:0] s;
        s = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        return s[DATA_WIDTH-1:0];
    endfunction

    // configuration registers
    data_t            kp_reg, kp_next;
    data_t            ki_reg, ki_next;
    logic [TS_W-1:0]  ts_reg, ts_next;
    data_t            scale_reg, scale_next;
    logic             aw_en_reg, aw_en_next;
    data_t            thr_reg, thr_next;
    data_t            upper_reg, upper_next;
    data_t            lower_reg, lower_next;

    // controller state
    state_t           state_reg, state_next;
    data_t            integ_reg, integ_next;
    data_t            latched_reg, latched_next;
    data_t            prev_err_reg, prev_err_next;
    logic             flag_reg, flag_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    // working values of the sample in flight
    in_item_t         sample_reg, sample_next;
    data_t            err_reg, err_next;
    data_t            p_reg, p_next;
    data_t            drive_reg, drive_next;

    // shared multiplier
    logic             mul_start;
    data_t            mul_a;
    data_t            mul_b;
    logic             mul_done;
    data_t            mul_prod;

    logic             cfg_wr;
    reg_addr_t        reg_sel;
    logic             out_free;
    data_t            clamped;

    pictrl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign reg_sel    = reg_addr_t'(paddr[ADDR_WIDTH-1:2]);
    assign meas_stall = (state_reg != ST_IDLE);
    assign ctrl_valid = out_valid_reg;
    assign ctrl       = out_data_reg;
    // output register is free when empty or being emptied by this transfer
    assign out_free   = !out_valid_reg || !ctrl_stall;

    // register read back
    always_comb
    begin
        unique case (reg_sel)
            REG_KP:    prdata = kp_reg;
            REG_KI:    prdata = ki_reg;
            REG_TS:    prdata = {1'b0, ts_reg};
            REG_SCALE: prdata = scale_reg;
            REG_AW_EN: prdata = {31'd0, aw_en_reg};
            REG_THR:   prdata = thr_reg;
            REG_UPPER: prdata = upper_reg;
            REG_LOWER: prdata = lower_reg;
            default:   prdata = '0;
        endcase
    end

    // configuration writes
    always_comb
    begin
        kp_next    = kp_reg;
        ki_next    = ki_reg;
        ts_next    = ts_reg;
        scale_next = scale_reg;
        aw_en_next = aw_en_reg;
        thr_next   = thr_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_KP:    kp_next    = pwdata;
                REG_KI:    ki_next    = pwdata;
                REG_TS:    ts_next    = pwdata[TS_W-1:0];
                REG_SCALE: scale_next = pwdata;
                REG_AW_EN: aw_en_next = pwdata[0];
                REG_THR:   thr_next   = pwdata;
                REG_UPPER: upper_next = pwdata;
                REG_LOWER: lower_next = pwdata;
                default:   ;
            endcase
        end
    end

    // clamp; with crossed limits the upper check wins
    always_comb
    begin
        if (drive_reg > upper_reg)
            clamped = upper_reg;
        else if (drive_reg < lower_reg)
            clamped = lower_reg;
        else
            clamped = drive_reg;
    end

    // sequencer: one multiply at a time on the shared unit
    always_comb
    begin
        state_next     = state_reg;
        integ_next     = integ_reg;
        latched_next   = latched_reg;
        prev_err_next  = prev_err_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sample_next    = sample_reg;
        err_next       = err_reg;
        p_next         = p_reg;
        drive_next     = drive_reg;
        mul_start      = 1'b0;
        mul_a          = mul_prod;
        mul_b          = mul_prod;

        // result transfer empties the output register
        if (out_valid_reg && !ctrl_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas_valid)
                begin
                    sample_next = meas;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                // error = (set point - measurement) * scale
                mul_start  = 1'b1;
                mul_a      = sat_sub(sample_reg.target_value, sample_reg.measured_value);
                mul_b      = scale_reg;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                if (mul_done)
                begin
                    err_next   = mul_prod;
                    state_next = ST_SUM_E;
                end
            end
            ST_SUM_E:
            begin
                // trapezoid: ki * (error + previous error)
                mul_start     = 1'b1;
                mul_a         = ki_reg;
                mul_b         = sat_add(err_reg, prev_err_reg);
                prev_err_next = err_reg;
                state_next    = ST_KI;
            end
            ST_KI:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = data_t'({1'b0, ts_reg});
                    mul_b      = mul_prod;
                    state_next = ST_TS;
                end
            end
            ST_TS:
            begin
                if (mul_done)
                begin
                    integ_next = sat_add(integ_reg, mul_prod);
                    mul_start  = 1'b1;
                    mul_a      = kp_reg;
                    mul_b      = err_reg;
                    state_next = ST_KP;
                end
            end
            ST_KP:
            begin
                if (mul_done)
                begin
                    p_next     = mul_prod;
                    state_next = ST_DRV;
                end
            end
            ST_DRV:
            begin
                drive_next = sat_add(p_reg, integ_reg);
                state_next = ST_AW;
            end
            ST_AW:
            begin
                if (aw_en_reg)
                begin
                    if (drive_reg <= thr_reg)
                    begin
                        latched_next = integ_reg;
                        flag_next    = 1'b1;
                    end
                    else
                    begin
                        // rebuild the output from the held integrator
                        drive_next = sat_add(p_reg, latched_reg);
                        flag_next  = 1'b0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.drive_value      = clamped;
                    out_data_next.integrating_flag = flag_reg;
                    state_next                     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            ts_reg        <= '0;
            scale_reg     <= data_t'(1) <<< FRAC_BITS;
            aw_en_reg     <= 1'b0;
            thr_reg       <= DATA_MAX;
            upper_reg     <= DATA_MAX;
            lower_reg     <= DATA_MIN;
            state_reg     <= ST_IDLE;
            integ_reg     <= '0;
            latched_reg   <= '0;
            prev_err_reg  <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            ts_reg        <= ts_next;
            scale_reg     <= scale_next;
            aw_en_reg     <= aw_en_next;
            thr_reg       <= thr_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            state_reg     <= state_next;
            integ_reg     <= integ_next;
            latched_reg   <= latched_next;
            prev_err_reg  <= prev_err_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        err_reg    <= err_next;
        p_reg      <= p_next;
        drive_reg  <= drive_next;
    end

endmodule

>>> rtl/core/pictrl_mul.sv
// bit-serial signed fixed-point multiplier with floor shift and saturation
module pictrl_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pictrl_pkg::data_t a,
    input  pictrl_pkg::data_t b,
    output logic              done,
    output pictrl_pkg::data_t prod
);
    import pictrl_pkg::*;

    localparam int CNT_W   = $clog2(DATA_WIDTH);
    localparam int SUM_W   = DATA_WIDTH + 2;
    localparam int GUARD_W = DATA_WIDTH - FRAC_BITS + 1;

    data_t                     a_reg, a_next;
    logic signed [DATA_WIDTH:0] hi_reg, hi_next;
    logic [DATA_WIDTH-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;

    logic                      last;
    logic signed [SUM_W-1:0]   addend;
    logic signed [SUM_W-1:0]   sum;
    logic [2*DATA_WIDTH-1:0]   full;
    logic [GUARD_W-1:0]        guard;

    always_comb
    begin
        last   = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
        addend = '0;
        // top bit of the multiplier carries negative weight
        if (lo_reg[0])
        begin
            addend = last ? -SUM_W'(a_reg) : SUM_W'(a_reg);
        end
        sum = SUM_W'(hi_reg) + addend;

        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (start)
        begin
            a_next   = a;
            hi_next  = '0;
            lo_next  = b;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            hi_next  = sum[SUM_W-1:1];
            lo_next  = {sum[0], lo_reg[DATA_WIDTH-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    // drop the fraction bits (floor), saturate if the upper bits are not a sign run
    assign full  = {hi_reg[DATA_WIDTH-1:0], lo_reg};
    assign guard = full[2*DATA_WIDTH-1:DATA_WIDTH+FRAC_BITS-1];
    assign prod  = ((&guard) || !(|guard)) ? data_t'(full[DATA_WIDTH+FRAC_BITS-1:FRAC_BITS])
                 : (guard[GUARD_W-1] ? DATA_MIN : DATA_MAX);
    assign done  = done_reg;

endmodule

>>> bench/pi_controller_trapezoid_antiwindup_top_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the pi controller: directed and random samples against a predictor
module pi_controller_trapezoid_antiwindup_top_tb;
    import pictrl_pkg::*;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 100;
    localparam int LONG_HOLD     = 800;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int MAX_REPORTS   = 10;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

    // predicts the drive value and flag of every accepted sample and checks the results
    class drive_checker;
        data_t                 kp, ki, scale, threshold, upper, lower;
        logic [DATA_WIDTH-2:0] ts;
        bit                    aw_on;
        data_t                 integ_acc, integ_latched, prev_err;
        bit                    windup_flag;
        out_item_t             expected_drives[$];
        int                    mismatches;

        function new();
            kp            = '0;
            ki            = '0;
            ts            = '0;
            scale         = data_t'(Q_ONE);
            aw_on         = 1'b0;
            threshold     = DATA_MAX;
            upper         = DATA_MAX;
            lower         = DATA_MIN;
            integ_acc     = '0;
            integ_latched = '0;
            prev_err      = '0;
            windup_flag   = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_register(int idx, logic [31:0] value);
            case (idx)
                REG_KP:    kp        = data_t'(value);
                REG_KI:    ki        = data_t'(value);
                REG_TS:    ts        = value[DATA_WIDTH-2:0];
                REG_SCALE: scale     = data_t'(value);
                REG_AW_EN: aw_on     = value[0];
                REG_THR:   threshold = data_t'(value);
                REG_UPPER: upper     = data_t'(value);
                REG_LOWER: lower     = data_t'(value);
                default: ;
            endcase
        endfunction

        function longint clip(longint x);
            if (x > longint'(DATA_MAX))
                return longint'(DATA_MAX);
            if (x < longint'(DATA_MIN))
                return longint'(DATA_MIN);
            return x;
        endfunction

        // q16.16 product, floor on the dropped fraction bits, then saturation
        function longint qmul(longint a, longint b);
            longint prod;
            prod = a * b;
            return clip(prod >>> FRAC_BITS);
        endfunction

        function void take_sample(in_item_t s);
            longint    err, inc, p, drive;
            out_item_t want;
            err = qmul(clip(longint'(s.target_value) - longint'(s.measured_value)), scale);
            // trapezoid: current plus previous error
            inc = qmul(longint'(ts), qmul(ki, clip(err + prev_err)));
            integ_acc = data_t'(clip(integ_acc + inc));
            p = qmul(kp, err);
            drive = clip(p + integ_acc);
            if (aw_on)
            begin
                if (drive <= threshold)
                begin
                    integ_latched = integ_acc;
                    windup_flag   = 1'b1;
                end
                else
                begin
                    drive       = clip(p + integ_latched);
                    windup_flag = 1'b0;
                end
            end
            // upper wins when the limits are crossed
            if (drive > upper)
                drive = upper;
            else if (drive < lower)
                drive = lower;
            prev_err = data_t'(err);
            want.drive_value      = data_t'(drive);
            want.integrating_flag = windup_flag;
            expected_drives.push_back(want);
        endfunction

        function void check_drive(out_item_t got);
            out_item_t want;
            bit        bad;
            if (expected_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result drive %0d flag %0b", $time,
                             got.drive_value, got.integrating_flag);
                return;
            end
            want = expected_drives.pop_front();
            bad  = 1'b0;
            if (got.drive_value !== want.drive_value)
                bad = 1'b1;
            if (got.integrating_flag !== want.integrating_flag)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected drive %0d flag %0b, got drive %0d flag %0b",
                             $time, want.drive_value, want.integrating_flag,
                             got.drive_value, got.integrating_flag);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  meas_valid = 1'b0;
    logic                  meas_stall;
    in_item_t              meas       = '0;
    logic                  ctrl_valid;
    logic                  ctrl_stall = 1'b0;
    out_item_t             ctrl;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    bit                    long_hold_req = 1'b0;
    int unsigned           cycle_count   = 0;
    logic [31:0]           reg_plan [NUM_REGS];
    in_item_t              batch[$];
    data_t                 track_target;
    data_t                 track_meas;
    drive_checker          drive_chk = new();

    pi_controller_trapezoid_antiwindup_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .meas       (meas),
        .ctrl_valid (ctrl_valid),
        .ctrl_stall (ctrl_stall),
        .ctrl       (ctrl),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result monitor: every transfer on the result channel is checked
    always @(posedge clk)
    begin
        if (rst_n && ctrl_valid && !ctrl_stall)
            drive_chk.check_drive(ctrl);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("pi_controller_trapezoid_antiwindup_top_tb: errors");
            $finish;
        end
    end

    // receiver: stall pattern in segments, plus one long hold-off on request
    initial
    begin : receiver
        stall_mode_t mode;
        int          seg_left;
        int          run_left;
        int          hold_left;
        logic        run_level;
        logic        next_stall;
        mode      = STALL_NONE;
        seg_left  = 0;
        run_left  = 0;
        hold_left = 0;
        run_level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                next_stall    = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 300);
                    mode     = stall_mode_t'($urandom_range(0, 3));
                end
                seg_left--;
                case (mode)
                    STALL_NONE:  next_stall = 1'b0;
                    STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_left  = $urandom_range(1, 40);
                            run_level = ~run_level;
                        end
                        run_left--;
                        next_stall = run_level;
                    end
                endcase
            end
            ctrl_stall <= next_stall;
        end
    end

    // one apb write; psel stays up so writes can run back to back
    task automatic apb_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        drive_chk.set_register(idx, value);
    endtask

    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(i, reg_plan[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void set_plan(logic [31:0] kp_v, logic [31:0] ki_v, logic [31:0] ts_v,
                                     logic [31:0] scale_v, logic [31:0] aw_v,
                                     logic [31:0] thr_v, logic [31:0] up_v,
                                     logic [31:0] lo_v);
        reg_plan[REG_KP]    = kp_v;
        reg_plan[REG_KI]    = ki_v;
        reg_plan[REG_TS]    = ts_v;
        reg_plan[REG_SCALE] = scale_v;
        reg_plan[REG_AW_EN] = aw_v;
        reg_plan[REG_THR]   = thr_v;
        reg_plan[REG_UPPER] = up_v;
        reg_plan[REG_LOWER] = lo_v;
    endfunction

    // mostly a modest signed value within +-span, now and then an extreme or raw bits
    function automatic logic [31:0] pick_word(logic [31:0] span);
        case ($urandom_range(0, 9))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return $urandom();
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    function automatic void plan_random_settings(int phase);
        logic [31:0] lim_hi;
        logic [31:0] lim_lo;
        lim_hi = $urandom_range(Q_ONE, 200 * Q_ONE);
        lim_lo = $urandom_range(Q_ONE, 200 * Q_ONE);
        reg_plan[REG_KP]    = pick_word(2 * Q_ONE);
        reg_plan[REG_KI]    = pick_word(Q_ONE);
        // top bit of the sample period is outside the register and must be dropped
        reg_plan[REG_TS]    = ($urandom_range(0, 7) == 0) ? $urandom()
                                                         : $urandom_range(0, Q_ONE / 8);
        reg_plan[REG_SCALE] = pick_word(4 * Q_ONE);
        reg_plan[REG_AW_EN] = (phase % 2 == 0) ? 32'd1 : 32'd0;
        reg_plan[REG_THR]   = pick_word(64 * Q_ONE);
        case ($urandom_range(0, 5))
            0:
            begin
                reg_plan[REG_UPPER] = DATA_MAX;
                reg_plan[REG_LOWER] = DATA_MIN;
            end
            1:
            begin
                // crossed limits
                reg_plan[REG_UPPER] = -lim_lo;
                reg_plan[REG_LOWER] = lim_hi;
            end
            default:
            begin
                reg_plan[REG_UPPER] = lim_hi;
                reg_plan[REG_LOWER] = -lim_lo;
            end
        endcase
    endfunction

    function automatic void add_sample(logic [31:0] m, logic [31:0] t);
        in_item_t s;
        s.measured_value = data_t'(m);
        s.target_value   = data_t'(t);
        batch.push_back(s);
    endfunction

    // plant-like sequence: measurement creeps toward the set point, with noise and outliers
    function automatic in_item_t next_random_sample();
        in_item_t s;
        data_t    noise;
        case ($urandom_range(0, 15))
            0, 1:
            begin
                s.measured_value = $urandom();
                s.target_value   = $urandom();
                return s;
            end
            2:
            begin
                s.measured_value = ($urandom_range(0, 1) == 1) ? DATA_MAX : DATA_MIN;
                s.target_value   = ($urandom_range(0, 2) == 0) ? data_t'(0)
                                 : ($urandom_range(0, 1) == 1) ? DATA_MAX : DATA_MIN;
                return s;
            end
            3: track_target = data_t'($urandom_range(0, 64 * Q_ONE) - 32 * Q_ONE);
            default: ;
        endcase
        noise      = data_t'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
        track_meas = track_meas + ((track_target - track_meas) >>> 3) + noise;
        s.measured_value = track_meas;
        s.target_value   = track_target;
        return s;
    endfunction

    // offer one sample and hold it until the block takes the transfer
    task automatic offer_sample(input in_item_t s);
        meas       <= s;
        meas_valid <= 1'b1;
        do
            @(posedge clk);
        while (meas_stall);
        drive_chk.take_sample(s);
    endtask

    // send the batch in bursts of random length with random gaps between them
    task automatic send_batch();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (batch[i])
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0:       gap = 0;
                    1:       gap = $urandom_range(1, 10);
                    default: gap = $urandom_range(1, 200);
                endcase
                if (gap > 0)
                begin
                    meas_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            offer_sample(batch[i]);
            burst_left--;
        end
        batch.delete();
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        meas_valid <= 1'b0;
        while (drive_chk.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: all gains zero, so the drive stays at zero
        add_sample(DATA_MIN, DATA_MAX);
        add_sample(DATA_MAX, DATA_MIN);
        add_sample(32'd0, 32'd0);
        send_batch();
        drain();

        // unity gains, half sample period, anti-windup off; error saturation both ways
        set_plan(Q_ONE, Q_ONE, 32'h0000_8000, Q_ONE, 32'd0, DATA_MAX, DATA_MAX, DATA_MIN);
        program_regs();
        add_sample(32'd0, 3 * Q_ONE);
        add_sample(DATA_MIN, DATA_MAX);
        add_sample(DATA_MAX, DATA_MIN);
        add_sample(-(5 * Q_ONE + Q_ONE / 4), 2 * Q_ONE);
        add_sample(32'd1, 32'd0);
        send_batch();
        drain();

        // anti-windup on, negative error scale: below and above the threshold, both clamps
        set_plan(2 * Q_ONE, Q_ONE / 4, 32'd655, -Q_ONE, 32'd1, 10 * Q_ONE, 20 * Q_ONE,
                 -(20 * Q_ONE));
        program_regs();
        add_sample(Q_ONE, 32'd0);
        add_sample(8 * Q_ONE, 32'd0);
        add_sample(30 * Q_ONE, 32'd0);
        add_sample(-(30 * Q_ONE), 32'd0);
        add_sample(32'd0, 32'd0);
        add_sample(DATA_MIN, DATA_MAX);
        add_sample(DATA_MAX, DATA_MIN);
        send_batch();
        drain();

        // crossed limits: lower above upper
        set_plan(Q_ONE, 32'd0, 32'd0, Q_ONE, 32'd0, DATA_MAX, -Q_ONE, Q_ONE);
        program_regs();
        add_sample(32'd0, 200 * Q_ONE);
        add_sample(32'd0, 32'd0);
        add_sample(32'd0, -(5 * Q_ONE));
        send_batch();
        drain();

        // extreme gains, full-width sample period write, threshold at the bottom
        set_plan(DATA_MIN, DATA_MAX, 32'hFFFF_FFFF, DATA_MIN, 32'd1, DATA_MIN, DATA_MAX,
                 DATA_MIN);
        program_regs();
        add_sample(32'd0, Q_ONE);
        add_sample(Q_ONE, 32'd0);
        add_sample(DATA_MAX, DATA_MIN);
        add_sample(DATA_MIN, DATA_MAX);
        add_sample(32'hFFFF_FFFF, 32'd0);
        send_batch();
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            plan_random_settings(phase);
            program_regs();
            track_target = data_t'($urandom_range(0, 64 * Q_ONE) - 32 * Q_ONE);
            track_meas   = data_t'($urandom_range(0, 64 * Q_ONE) - 32 * Q_ONE);
            for (int n = 0; n < PHASE_SAMPLES; n++)
                batch.push_back(next_random_sample());
            // receiver backs off long enough for the block to fill and stall its input
            if (phase == 2 || phase == 5)
                long_hold_req = 1'b1;
            send_batch();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (drive_chk.mismatches == 0 && drive_chk.pending() == 0)
            $display("pi_controller_trapezoid_antiwindup_top_tb: clean");
        else
            $display("pi_controller_trapezoid_antiwindup_top_tb: errors");
        $finish;
    end

endmodule
